// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/vmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared constants for the 4x4 matrix vector transform unit.
// ----------------------------------------------------------------------------
package vmt_pkg;

    localparam int VEC_LEN            = 4;
    localparam int LANE_W             = 32;
    localparam int STREAM_W           = VEC_LEN * LANE_W;

    localparam int DEFAULT_COORD_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS   = 16;

    localparam int NUM_REGS    = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_ADDR_W  = CFG_IDX_LSB + CFG_IDX_W;

endpackage

// ===== rtl/vmt_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_regs
// APB register file holding the 4x4 matrix, two entries per 64-bit register.
// ----------------------------------------------------------------------------
module vmt_regs #(
    parameter int COORD_WIDTH = vmt_pkg::DEFAULT_COORD_WIDTH,
    parameter int FRAC_BITS   = vmt_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [vmt_pkg::CFG_ADDR_W-1:0]                paddr,
    input  logic [vmt_pkg::CFG_DATA_W-1:0]                pwdata,
    output logic [vmt_pkg::CFG_DATA_W-1:0]                prdata,
    output logic                                          pready,
    output logic [3:0][3:0][COORD_WIDTH-1:0]              matrix
);

    localparam logic [vmt_pkg::LANE_W-1:0] ONE = vmt_pkg::LANE_W'(1) << FRAC_BITS;

    logic [vmt_pkg::CFG_DATA_W-1:0] cfg_reg [vmt_pkg::NUM_REGS];
    logic [vmt_pkg::CFG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign idx    = paddr[vmt_pkg::CFG_ADDR_W-1:vmt_pkg::CFG_IDX_LSB];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = cfg_reg[idx];

    // Register k holds row k/2, columns 2*(k%2) and 2*(k%2)+1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < vmt_pkg::NUM_REGS; k++)
            begin
                if ((k & 1) == ((k >> 1) >> 1))
                begin
                    if (((k >> 1) & 1) == 1)
                        cfg_reg[k] <= {ONE, {vmt_pkg::LANE_W{1'b0}}};
                    else
                        cfg_reg[k] <= {{vmt_pkg::LANE_W{1'b0}}, ONE};
                end
                else
                begin
                    cfg_reg[k] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            cfg_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                matrix[i][j] = cfg_reg[2 * i + j / 2][vmt_pkg::LANE_W * (j % 2) +: COORD_WIDTH];
            end
        end
    end

endmodule

// ===== rtl/vmt_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_mul
// Input register and the sixteen registered products v_i * m[i][j].
// ----------------------------------------------------------------------------
module vmt_mul #(
    parameter int COORD_WIDTH = vmt_pkg::DEFAULT_COORD_WIDTH,
    localparam int PROD_W     = 2 * COORD_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [vmt_pkg::STREAM_W-1:0]           in_data,
    input  logic [3:0][3:0][COORD_WIDTH-1:0]       matrix,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [3:0][3:0][PROD_W-1:0]            prod
);

    logic                          v1_valid_reg;
    logic                          v2_valid_reg;
    logic [3:0][COORD_WIDTH-1:0]   vec_reg;
    logic [3:0][3:0][PROD_W-1:0]   prod_reg;
    logic [3:0][3:0][PROD_W-1:0]   prod_next;
    logic                          en1;
    logic                          en2;

    // A stage advances when it is empty or the one after it advances.
    assign en2      = !v2_valid_reg || out_ready;
    assign en1      = !v1_valid_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_valid_reg <= in_valid;
            if (en2)
                v2_valid_reg <= v1_valid_reg;
        end
    end

    // Only the low COORD_WIDTH bits of each lane take part.
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            for (int i = 0; i < 4; i++)
                vec_reg[i] <= in_data[vmt_pkg::LANE_W * i +: COORD_WIDTH];
        end
        if (en2 && v1_valid_reg)
            prod_reg <= prod_next;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[i][j] = $signed(vec_reg[i]) * $signed(matrix[i][j]);
            end
        end
    end

    assign out_valid = v2_valid_reg;
    assign prod      = prod_reg;

endmodule

// ===== rtl/vmt_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_acc
// Column sums in two adder levels, floor shift, saturation, output register.
// ----------------------------------------------------------------------------
module vmt_acc #(
    parameter int COORD_WIDTH = vmt_pkg::DEFAULT_COORD_WIDTH,
    parameter int FRAC_BITS   = vmt_pkg::DEFAULT_FRAC_BITS,
    localparam int PROD_W     = 2 * COORD_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [3:0][3:0][PROD_W-1:0]            prod,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [vmt_pkg::STREAM_W-1:0]           out_data,
    output logic                                   out_sat
);

    localparam int HALF_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - FRAC_BITS;
    localparam int EXT_W  = (SH_W > COORD_WIDTH) ? SH_W : COORD_WIDTH + 1;

    logic                                  v3_valid_reg;
    logic                                  v4_valid_reg;
    logic                                  v5_valid_reg;
    logic                                  en3;
    logic                                  en4;
    logic                                  en5;

    logic [3:0][1:0][HALF_W-1:0]           half_reg;
    logic [3:0][1:0][HALF_W-1:0]           half_next;
    logic [3:0][SH_W-1:0]                  sh_reg;
    logic [3:0][SH_W-1:0]                  sh_next;
    logic [vmt_pkg::STREAM_W-1:0]          data_reg;
    logic [vmt_pkg::STREAM_W-1:0]          data_next;
    logic                                  sat_reg;
    logic                                  sat_next;

    logic signed [SUM_W-1:0]               sum_c  [4];
    logic signed [EXT_W-1:0]               ext_c  [4];
    logic [EXT_W-COORD_WIDTH:0]            top_c  [4];
    logic [COORD_WIDTH-1:0]                res_c  [4];
    logic [3:0]                            clip_c;

    assign en5      = !v5_valid_reg || out_ready;
    assign en4      = !v4_valid_reg || en5;
    assign en3      = !v3_valid_reg || en4;
    assign in_ready = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_valid_reg <= 1'b0;
            v4_valid_reg <= 1'b0;
            v5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_valid_reg <= in_valid;
            if (en4)
                v4_valid_reg <= v3_valid_reg;
            if (en5)
                v5_valid_reg <= v4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
            half_reg <= half_next;
        if (en4 && v3_valid_reg)
            sh_reg <= sh_next;
        if (en5 && v4_valid_reg)
        begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

    // First adder level: rows 0+1 and rows 2+3 of each column.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            half_next[j][0] = HALF_W'($signed(prod[0][j])) + HALF_W'($signed(prod[1][j]));
            half_next[j][1] = HALF_W'($signed(prod[2][j])) + HALF_W'($signed(prod[3][j]));
        end
    end

    // Second level and arithmetic shift, which floors toward minus infinity.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sum_c[j]   = SUM_W'($signed(half_reg[j][0])) + SUM_W'($signed(half_reg[j][1]));
            sh_next[j] = SH_W'(sum_c[j] >>> FRAC_BITS);
        end
    end

    // Clip when the bits from the sign down to bit COORD_WIDTH-1 disagree.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            ext_c[j]  = EXT_W'($signed(sh_reg[j]));
            top_c[j]  = ext_c[j][EXT_W-1:COORD_WIDTH-1];
            clip_c[j] = !((&top_c[j]) || !(|top_c[j]));
            if (!clip_c[j])
                res_c[j] = ext_c[j][COORD_WIDTH-1:0];
            else if (ext_c[j][EXT_W-1])
                res_c[j] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            else
                res_c[j] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            data_next[vmt_pkg::LANE_W * j +: vmt_pkg::LANE_W] =
                vmt_pkg::LANE_W'($signed(res_c[j]));
        end
        sat_next = |clip_c;
    end

    assign out_valid = v5_valid_reg;
    assign out_data  = data_reg;
    assign out_sat   = sat_reg;

endmodule

// ===== rtl/vector4_matrix_transform_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector4_matrix_transform_unit
// Streaming 4x4 matrix times row vector transform in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one vector per transfer: x, y, z, w in 32-bit lanes.
//   m_* returns out_x..out_w in the same lanes, and m_tuser flags that at
//   least one component was clipped to the signed COORD_WIDTH range.
//   The matrix sits in eight 64-bit registers on the APB port (row i,
//   columns 0/1 at byte 16*i, columns 2/3 at byte 16*i+8); write it only
//   while no vector is in flight.
// Timing:
//   Five register stages: input, products, pair sums, column sum and shift,
//   saturation/output. A vector taken on s_tready passes them in that order
//   to m_tvalid; one vector is taken every cycle while m_tready stays high.
//   The sixteen 32x32 multipliers and the 66-bit column adder set the pace.
// Reset:
//   rst_n clears all stage valid bits and loads the identity matrix.
// Stall:
//   With m_tready low, the output register holds; earlier stages keep
//   filling bubbles, and s_tready drops once every stage holds a vector.
// ----------------------------------------------------------------------------
module vector4_matrix_transform_unit #(
    parameter int COORD_WIDTH = vmt_pkg::DEFAULT_COORD_WIDTH,
    parameter int FRAC_BITS   = vmt_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vmt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [vmt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vmt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    // input vectors
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vmt_pkg::STREAM_W-1:0]      s_tdata,   // vec_x, vec_y, vec_z, vec_w
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vmt_pkg::STREAM_W-1:0]      m_tdata,   // out_x, out_y, out_z, out_w
    output logic                              m_tuser    // saturated
);

    localparam int PROD_W = 2 * COORD_WIDTH;

    logic [3:0][3:0][COORD_WIDTH-1:0] matrix;
    logic [3:0][3:0][PROD_W-1:0]      prod;
    logic                             prod_valid;
    logic                             prod_ready;

    vmt_regs #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .matrix  (matrix)
    );

    vmt_mul #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .matrix    (matrix),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .prod      (prod)
    );

    vmt_acc #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .prod      (prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_sat   (m_tuser)
    );

endmodule

// ===== rtl/vmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_checker
// Port-level checks on the transform unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmt_checker #(
    parameter int COORD_WIDTH = vmt_pkg::DEFAULT_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [vmt_pkg::STREAM_W-1:0]  m_tdata,
    input  logic                          m_tuser
);

    localparam logic [vmt_pkg::LANE_W-1:0] SAT_MAX =
        vmt_pkg::LANE_W'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    localparam logic [vmt_pkg::LANE_W-1:0] SAT_MIN =
        vmt_pkg::LANE_W'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));

    logic [3:0] at_limit;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            at_limit[j] = (m_tdata[vmt_pkg::LANE_W * j +: vmt_pkg::LANE_W] == SAT_MAX) ||
                          (m_tdata[vmt_pkg::LANE_W * j +: vmt_pkg::LANE_W] == SAT_MIN);
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_IMPLY(a_ready_when_drain, clk, rst_n, !m_tvalid || m_tready, s_tready)
    `ASSERT_IMPLY(a_sat_at_limit, clk, rst_n, m_tvalid && m_tuser, |at_limit)
    `ASSERT_IMPLY(a_empty_after_reset, clk, rst_n, $rose(rst_n), !m_tvalid)

endmodule

bind vector4_matrix_transform_unit vmt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_vmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
